[src/tts_pkg.sv]
`default_nettype none

package tts_pkg;

	// Default sizes and fixed field widths
	localparam int COORD_WIDTH_DEF = 24;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int UV_W            = 18;
	localparam int NORM_W          = 16;
	localparam int OUT_W           = 32;
	localparam int FRAC_W          = 16;
	localparam int DUV_W           = UV_W + 1;
	localparam int DET_W           = 2 * DUV_W + 1;
	localparam int QUO_W           = OUT_W + 1;

	// Queue fill status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Back end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_ACC,
		BK_DINIT,
		BK_DPREP,
		BK_DIV,
		BK_FIN,
		BK_DONE
	} bk_state_t;

	// Accumulator operations on the registered product
	typedef enum logic [2:0] {
		ACT_LOAD,
		ACT_LOAD_SH,
		ACT_ADD,
		ACT_ADD_SH,
		ACT_SUB
	} act_t;

	// Width of one packed job: edge vectors e1 and e2, four UV deltas, one normal
	function automatic int job_w(input int cw);
		return 6 * (cw + 1) + 4 * DUV_W + 3 * NORM_W;
	endfunction

endpackage

`default_nettype wire

[src/tts_front.sv]
`default_nettype none

module tts_front #(
	parameter int CW = tts_pkg::COORD_WIDTH_DEF,
	parameter int JW = tts_pkg::job_w(tts_pkg::COORD_WIDTH_DEF)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic signed [CW-1:0]             pos_x,
	input  wire logic signed [CW-1:0]             pos_y,
	input  wire logic signed [CW-1:0]             pos_z,
	input  wire logic signed [tts_pkg::UV_W-1:0]  tex_u,
	input  wire logic signed [tts_pkg::UV_W-1:0]  tex_v,
	input  wire logic signed [tts_pkg::NORM_W-1:0] norm_x,
	input  wire logic signed [tts_pkg::NORM_W-1:0] norm_y,
	input  wire logic signed [tts_pkg::NORM_W-1:0] norm_z,
	input  wire logic                             first_of_face,
	input  wire logic                             tangent_enable,
	input  wire tts_pkg::q_status_t               q_status,
	output logic                                  push,
	output logic [JW-1:0]                         job
);
	import tts_pkg::*;

	localparam int EW = CW + 1;
	localparam logic [2:0] VI_THIRD  = 3'd2;
	localparam logic [2:0] VI_FOURTH = 3'd3;
	localparam logic [2:0] VI_PAST   = 3'd4;

	logic [2:0] vi_q;
	logic [2:0] k;
	logic       accept;
	logic       is_fourth;

	logic signed [CW-1:0]     px_q [3];
	logic signed [CW-1:0]     py_q [3];
	logic signed [CW-1:0]     pz_q [3];
	logic signed [UV_W-1:0]   tu_q [3];
	logic signed [UV_W-1:0]   tv_q [3];
	logic signed [NORM_W-1:0] nx_q [3];
	logic signed [NORM_W-1:0] ny_q [3];
	logic signed [NORM_W-1:0] nz_q [3];

	logic signed [CW-1:0]     p0x, p0y, p0z, p1x, p1y, p1z, p2x, p2y, p2z;
	logic signed [UV_W-1:0]   u0, v0, u1, v1, u2, v2;
	logic signed [NORM_W-1:0] nx, ny, nz;
	logic signed [EW-1:0]     e1x, e1y, e1z, e2x, e2y, e2z;
	logic signed [DUV_W-1:0]  du1, dv1, du2, dv2;

	// Classify the vertex by its place in the face
	assign k         = first_of_face ? 3'd0 : vi_q;
	assign in_stall  = q_status.full;
	assign accept    = in_valid && !in_stall;
	assign is_fourth = (k == VI_FOURTH);
	assign push      = accept && tangent_enable && ((k == VI_THIRD) || is_fourth);

	// Advance the vertex counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vi_q <= '0;
		end else if (accept) begin
			vi_q <= (k == VI_PAST) ? VI_PAST : k + 3'd1;
		end
	end

	// Hold vertices a, b, c of the face
	always_ff @(posedge clk) begin
		if (accept && (k <= VI_THIRD)) begin
			px_q[k[1:0]] <= pos_x;
			py_q[k[1:0]] <= pos_y;
			pz_q[k[1:0]] <= pos_z;
			tu_q[k[1:0]] <= tex_u;
			tv_q[k[1:0]] <= tex_v;
			nx_q[k[1:0]] <= norm_x;
			ny_q[k[1:0]] <= norm_y;
			nz_q[k[1:0]] <= norm_z;
		end
	end

	// Pick triangle (a,b,c) or (c,d,a)
	always_comb begin
		p0x = is_fourth ? px_q[2] : px_q[0];
		p0y = is_fourth ? py_q[2] : py_q[0];
		p0z = is_fourth ? pz_q[2] : pz_q[0];
		u0  = is_fourth ? tu_q[2] : tu_q[0];
		v0  = is_fourth ? tv_q[2] : tv_q[0];
		p1x = is_fourth ? pos_x : px_q[1];
		p1y = is_fourth ? pos_y : py_q[1];
		p1z = is_fourth ? pos_z : pz_q[1];
		u1  = is_fourth ? tex_u : tu_q[1];
		v1  = is_fourth ? tex_v : tv_q[1];
		p2x = is_fourth ? px_q[0] : pos_x;
		p2y = is_fourth ? py_q[0] : pos_y;
		p2z = is_fourth ? pz_q[0] : pos_z;
		u2  = is_fourth ? tu_q[0] : tex_u;
		v2  = is_fourth ? tv_q[0] : tex_v;
		nx  = is_fourth ? nx_q[2] : nx_q[0];
		ny  = is_fourth ? ny_q[2] : ny_q[0];
		nz  = is_fourth ? nz_q[2] : nz_q[0];
	end

	// Form edges and UV deltas
	assign e1x = EW'(p1x) - EW'(p0x);
	assign e1y = EW'(p1y) - EW'(p0y);
	assign e1z = EW'(p1z) - EW'(p0z);
	assign e2x = EW'(p2x) - EW'(p0x);
	assign e2y = EW'(p2y) - EW'(p0y);
	assign e2z = EW'(p2z) - EW'(p0z);
	assign du1 = DUV_W'(u1) - DUV_W'(u0);
	assign dv1 = DUV_W'(v1) - DUV_W'(v0);
	assign du2 = DUV_W'(u2) - DUV_W'(u0);
	assign dv2 = DUV_W'(v2) - DUV_W'(v0);

	assign job = {e1x, e1y, e1z, e2x, e2y, e2z, du1, dv1, du2, dv2, nx, ny, nz};

endmodule

`default_nettype wire

[src/tts_queue.sv]
`default_nettype none

module tts_queue #(
	parameter int W     = 8,
	parameter int DEPTH = tts_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire logic [W-1:0]   din,
	input  wire logic           pop,
	output logic [W-1:0]        dout,
	output tts_pkg::q_status_t  status
);
	import tts_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0]   PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

	logic [W-1:0]    mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] cnt_q;

	assign status.full  = (cnt_q == CNT_FULL);
	assign status.empty = (cnt_q == '0);
	assign dout         = mem_q[rd_ptr_q];

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[src/tts_back.sv]
`default_nettype none

module tts_back #(
	parameter int CW = tts_pkg::COORD_WIDTH_DEF,
	parameter int JW = tts_pkg::job_w(tts_pkg::COORD_WIDTH_DEF)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tts_pkg::q_status_t             q_status,
	input  wire logic [JW-1:0]                  job,
	output logic                                pop,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [tts_pkg::OUT_W-1:0]    tan_x,
	output logic signed [tts_pkg::OUT_W-1:0]    tan_y,
	output logic signed [tts_pkg::OUT_W-1:0]    tan_z,
	output logic signed [tts_pkg::OUT_W-1:0]    bitan_x,
	output logic signed [tts_pkg::OUT_W-1:0]    bitan_y,
	output logic signed [tts_pkg::OUT_W-1:0]    bitan_z,
	output logic                                degenerate,
	output logic                                clipped
);
	import tts_pkg::*;

	localparam int EW   = CW + 1;
	localparam int CCW  = CW + 18;
	localparam int LO_W = 17;
	localparam int MW   = (EW > DUV_W) ? EW : DUV_W;
	localparam int PRW  = 2 * MW;
	localparam int AW   = 2 * CW + 21;
	localparam int NW   = CW + 21;
	localparam int CMPW = NW + DET_W + LO_W;
	localparam logic [3:0] ST_DET_CHECK = 4'd2;
	localparam logic [3:0] ST_SETUP_END = 4'd13;
	localparam logic [2:0] COMP_BITAN   = 3'd3;
	localparam logic [2:0] COMP_LAST    = 3'd5;
	localparam logic [5:0] DIV_LAST     = 6'(QUO_W - 1);

	bk_state_t state_q, state_d;

	// Unpacked job fields
	logic signed [EW-1:0]     j_e1x, j_e1y, j_e1z, j_e2x, j_e2y, j_e2z;
	logic signed [DUV_W-1:0]  j_du1, j_dv1, j_du2, j_dv2;
	logic signed [NORM_W-1:0] j_nx, j_ny, j_nz;

	logic signed [EW-1:0]     e1_q [3];
	logic signed [EW-1:0]     e2_q [3];
	logic signed [DUV_W-1:0]  du1_q, dv1_q, du2_q, dv2_q;
	logic signed [NORM_W-1:0] nx_q, ny_q, nz_q;
	logic signed [DET_W-1:0]  det_q;
	logic [DET_W-1:0]         ud_q;
	logic signed [CCW-1:0]    c_q [3];
	logic signed [AW-1:0]     acc_q;
	logic signed [PRW-1:0]    prod_q;
	logic [3:0]               st_q;
	logic                     num_ph_q;
	logic [2:0]               comp_q;
	logic                     flip_q;
	logic                     degen_q;
	logic                     clip_q;
	logic [NW-1:0]            un_q;
	logic                     neg_q;
	logic                     ovf_q;
	logic [DET_W:0]           rem_q;
	logic [QUO_W-1:0]         nsh_q;
	logic [QUO_W-1:0]         quo_q;
	logic [5:0]               cnt_q;
	logic [OUT_W-1:0]         res_q [6];

	logic                     out_valid_q;
	logic [OUT_W-1:0]         tan_x_q, tan_y_q, tan_z_q, bitan_x_q, bitan_y_q, bitan_z_q;
	logic                     degen_out_q, clip_out_q;

	logic signed [MW-1:0]     op_a, op_b;
	act_t                     act;
	logic [1:0]               lane;
	logic                     is_tan;
	logic signed [AW-1:0]     prod_ext, prod_sh, acc_d;
	logic signed [NW-1:0]     num_v;
	logic [NW-1:0]            un_d;
	logic [DET_W:0]           trial;
	logic                     ge;
	logic [QUO_W-1:0]         lim, mag_v, mag_neg;
	logic                     sat;
	logic [OUT_W-1:0]         res_v;
	logic                     out_load;

	assign {j_e1x, j_e1y, j_e1z, j_e2x, j_e2y, j_e2z,
		j_du1, j_dv1, j_du2, j_dv2, j_nx, j_ny, j_nz} = job;

	assign is_tan = (comp_q < COMP_BITAN);
	assign lane   = is_tan ? comp_q[1:0] : 2'(comp_q - COMP_BITAN);

	// Select multiplier operands and accumulator action for this step
	always_comb begin
		op_a = '0;
		op_b = '0;
		act  = ACT_LOAD;
		if (!num_ph_q) begin
			unique case (st_q)
				4'd0: begin op_a = MW'(du1_q); op_b = MW'(dv2_q); act = ACT_LOAD; end
				4'd1: begin op_a = MW'(du2_q); op_b = MW'(dv1_q); act = ACT_SUB; end
				4'd2: begin op_a = MW'(e2_q[1]); op_b = MW'(nz_q); act = ACT_LOAD; end
				4'd3: begin op_a = MW'(e2_q[2]); op_b = MW'(ny_q); act = ACT_SUB; end
				4'd4: begin op_a = MW'(e2_q[2]); op_b = MW'(nx_q); act = ACT_LOAD; end
				4'd5: begin op_a = MW'(e2_q[0]); op_b = MW'(nz_q); act = ACT_SUB; end
				4'd6: begin op_a = MW'(e2_q[0]); op_b = MW'(ny_q); act = ACT_LOAD; end
				4'd7: begin op_a = MW'(e2_q[1]); op_b = MW'(nx_q); act = ACT_SUB; end
				4'd8: begin
					op_a = MW'(e1_q[0]);
					op_b = MW'($signed(c_q[0][CCW-1:LO_W]));
					act  = ACT_LOAD_SH;
				end
				4'd9: begin
					op_a = MW'(e1_q[0]);
					op_b = MW'({1'b0, c_q[0][LO_W-1:0]});
					act  = ACT_ADD;
				end
				4'd10: begin
					op_a = MW'(e1_q[1]);
					op_b = MW'($signed(c_q[1][CCW-1:LO_W]));
					act  = ACT_ADD_SH;
				end
				4'd11: begin
					op_a = MW'(e1_q[1]);
					op_b = MW'({1'b0, c_q[1][LO_W-1:0]});
					act  = ACT_ADD;
				end
				4'd12: begin
					op_a = MW'(e1_q[2]);
					op_b = MW'($signed(c_q[2][CCW-1:LO_W]));
					act  = ACT_ADD_SH;
				end
				4'd13: begin
					op_a = MW'(e1_q[2]);
					op_b = MW'({1'b0, c_q[2][LO_W-1:0]});
					act  = ACT_ADD;
				end
				default: begin
					op_a = '0;
					op_b = '0;
					act  = ACT_LOAD;
				end
			endcase
		end else if (is_tan) begin
			op_a = st_q[0] ? MW'(dv1_q) : MW'(dv2_q);
			op_b = st_q[0] ? MW'(e2_q[lane]) : MW'(e1_q[lane]);
			act  = st_q[0] ? ACT_SUB : ACT_LOAD;
		end else begin
			op_a = st_q[0] ? MW'(du2_q) : MW'(du1_q);
			op_b = st_q[0] ? MW'(e1_q[lane]) : MW'(e2_q[lane]);
			act  = st_q[0] ? ACT_SUB : ACT_LOAD;
		end
	end

	// Apply the action to the accumulator
	assign prod_ext = AW'(prod_q);
	assign prod_sh  = prod_ext <<< LO_W;

	always_comb begin
		unique case (act)
			ACT_LOAD:    acc_d = prod_ext;
			ACT_LOAD_SH: acc_d = prod_sh;
			ACT_ADD:     acc_d = acc_q + prod_ext;
			ACT_ADD_SH:  acc_d = acc_q + prod_sh;
			ACT_SUB:     acc_d = acc_q - prod_ext;
			default:     acc_d = acc_q;
		endcase
	end

	// Divider helpers
	assign num_v = $signed(acc_q[NW-1:0]);
	assign un_d  = num_v[NW-1] ? NW'(-num_v) : NW'(num_v);
	assign trial = {rem_q[DET_W-1:0], nsh_q[QUO_W-1]};
	assign ge    = (trial >= {1'b0, ud_q});

	// Saturate and sign the quotient
	always_comb begin
		lim     = neg_q ? {2'b01, {(OUT_W - 1){1'b0}}} : {2'b00, {(OUT_W - 1){1'b1}}};
		sat     = ovf_q || (quo_q > lim);
		mag_v   = sat ? lim : quo_q;
		mag_neg = QUO_W'(0) - mag_v;
		res_v   = neg_q ? mag_neg[OUT_W-1:0] : mag_v[OUT_W-1:0];
	end

	assign out_load = (state_q == BK_DONE) && (!out_valid_q || !out_stall);

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and queue pop
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					pop     = 1'b1;
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				if (!num_ph_q && (st_q == ST_DET_CHECK) && (det_q == '0)) begin
					state_d = BK_DONE;
				end else begin
					state_d = BK_ACC;
				end
			end
			BK_ACC: begin
				state_d = (num_ph_q && st_q[0]) ? BK_DINIT : BK_MUL;
			end
			BK_DINIT: state_d = BK_DPREP;
			BK_DPREP: state_d = BK_DIV;
			BK_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				state_d = (comp_q == COMP_LAST) ? BK_DONE : BK_MUL;
			end
			BK_DONE: begin
				if (out_load) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			num_ph_q <= 1'b0;
			comp_q   <= '0;
			cnt_q    <= '0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					st_q     <= '0;
					num_ph_q <= 1'b0;
					comp_q   <= '0;
				end
				BK_ACC: begin
					if (!num_ph_q) begin
						if (st_q == ST_SETUP_END) begin
							st_q     <= '0;
							num_ph_q <= 1'b1;
						end else begin
							st_q <= st_q + 4'd1;
						end
					end else begin
						st_q <= st_q[0] ? 4'd0 : 4'd1;
					end
				end
				BK_DPREP: cnt_q <= '0;
				BK_DIV:   cnt_q <= cnt_q + 6'd1;
				BK_FIN: begin
					if (comp_q != COMP_LAST) begin
						comp_q <= comp_q + 3'd1;
					end
				end
				default: begin
					st_q <= st_q;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				e1_q[0] <= j_e1x;
				e1_q[1] <= j_e1y;
				e1_q[2] <= j_e1z;
				e2_q[0] <= j_e2x;
				e2_q[1] <= j_e2y;
				e2_q[2] <= j_e2z;
				du1_q   <= j_du1;
				dv1_q   <= j_dv1;
				du2_q   <= j_du2;
				dv2_q   <= j_dv2;
				nx_q    <= j_nx;
				ny_q    <= j_ny;
				nz_q    <= j_nz;
				degen_q <= 1'b0;
				clip_q  <= 1'b0;
			end
			BK_MUL: begin
				prod_q <= op_a * op_b;
				if (!num_ph_q && (st_q == ST_DET_CHECK)) begin
					ud_q <= det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
					if (det_q == '0) begin
						degen_q <= 1'b1;
					end
				end
				if (num_ph_q && (comp_q == '0) && (st_q == '0)) begin
					flip_q <= (acc_q != '0) && (acc_q[AW-1] != det_q[DET_W-1]);
				end
			end
			BK_ACC: begin
				acc_q <= acc_d;
				if (!num_ph_q) begin
					unique case (st_q)
						4'd1:    det_q  <= acc_d[DET_W-1:0];
						4'd3:    c_q[0] <= acc_d[CCW-1:0];
						4'd5:    c_q[1] <= acc_d[CCW-1:0];
						4'd7:    c_q[2] <= acc_d[CCW-1:0];
						default: det_q  <= det_q;
					endcase
				end
			end
			BK_DINIT: begin
				un_q  <= un_d;
				neg_q <= acc_q[AW-1] ^ det_q[DET_W-1] ^ (flip_q && is_tan);
			end
			BK_DPREP: begin
				ovf_q <= (CMPW'(un_q) >= (CMPW'(ud_q) << LO_W));
				rem_q <= (DET_W + 1)'(un_q >> LO_W);
				nsh_q <= {un_q[LO_W-1:0], {FRAC_W{1'b0}}};
				quo_q <= '0;
			end
			BK_DIV: begin
				rem_q <= ge ? (trial - {1'b0, ud_q}) : trial;
				quo_q <= {quo_q[QUO_W-2:0], ge};
				nsh_q <= nsh_q << 1;
			end
			BK_FIN: begin
				res_q[comp_q] <= res_v;
				if (sat) begin
					clip_q <= 1'b1;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			tan_x_q     <= degen_q ? '0 : res_q[0];
			tan_y_q     <= degen_q ? '0 : res_q[1];
			tan_z_q     <= degen_q ? '0 : res_q[2];
			bitan_x_q   <= degen_q ? '0 : res_q[3];
			bitan_y_q   <= degen_q ? '0 : res_q[4];
			bitan_z_q   <= degen_q ? '0 : res_q[5];
			degen_out_q <= degen_q;
			clip_out_q  <= clip_q && !degen_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign tan_x      = tan_x_q;
	assign tan_y      = tan_y_q;
	assign tan_z      = tan_z_q;
	assign bitan_x    = bitan_x_q;
	assign bitan_y    = bitan_y_q;
	assign bitan_z    = bitan_z_q;
	assign degenerate = degen_out_q;
	assign clipped    = clip_out_q;

endmodule

`default_nettype wire

[src/triangle_tangent_space.sv]
// channel  dir  handshake              payload
// cfg      in   cfg_valid / cfg_ready  cfg_data (tangent_enable)
// in       in   in_valid / in_stall    pos_*, tex_*, norm_*, first_of_face
// out      out  out_valid / out_stall  tan_*, bitan_*, degenerate, clipped
//
// A vertex is taken whenever the job queue has room; with tangent_enable set, only the third
// and fourth vertex of a face push a job.
// The back end takes a new job only when it is idle. A job runs 14 shared multiply steps,
// then for each of six components the numerator steps, the divider setup and
// the one-bit restoring divider.
// A zero determinant ends a job at the determinant check.
// Reset clears the vertex counter, the queue, the sequencer and tangent_enable.
// A stalled result waits in the output register; the back end then holds its
// finished job, the queue fills and in_stall rises.
`default_nettype none

module triangle_tangent_space #(
	parameter int COORD_WIDTH = tts_pkg::COORD_WIDTH_DEF,
	parameter int QUEUE_DEPTH = tts_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic                              cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [COORD_WIDTH-1:0]     pos_x,
	input  wire logic signed [COORD_WIDTH-1:0]     pos_y,
	input  wire logic signed [COORD_WIDTH-1:0]     pos_z,
	input  wire logic signed [tts_pkg::UV_W-1:0]   tex_u,
	input  wire logic signed [tts_pkg::UV_W-1:0]   tex_v,
	input  wire logic signed [tts_pkg::NORM_W-1:0] norm_x,
	input  wire logic signed [tts_pkg::NORM_W-1:0] norm_y,
	input  wire logic signed [tts_pkg::NORM_W-1:0] norm_z,
	input  wire logic                              first_of_face,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [tts_pkg::OUT_W-1:0]       tan_x,
	output logic signed [tts_pkg::OUT_W-1:0]       tan_y,
	output logic signed [tts_pkg::OUT_W-1:0]       tan_z,
	output logic signed [tts_pkg::OUT_W-1:0]       bitan_x,
	output logic signed [tts_pkg::OUT_W-1:0]       bitan_y,
	output logic signed [tts_pkg::OUT_W-1:0]       bitan_z,
	output logic                                   degenerate,
	output logic                                   clipped
);
	import tts_pkg::*;

	localparam int JW = job_w(COORD_WIDTH);

	logic          tangent_enable_q;
	logic          push;
	logic          pop;
	logic [JW-1:0] job_in;
	logic [JW-1:0] job_out;
	q_status_t     q_status;

	// Take configuration writes at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tangent_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			tangent_enable_q <= cfg_data;
		end
	end

	tts_front #(
		.CW(COORD_WIDTH),
		.JW(JW)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.tex_u          (tex_u),
		.tex_v          (tex_v),
		.norm_x         (norm_x),
		.norm_y         (norm_y),
		.norm_z         (norm_z),
		.first_of_face  (first_of_face),
		.tangent_enable (tangent_enable_q),
		.q_status       (q_status),
		.push           (push),
		.job            (job_in)
	);

	tts_queue #(
		.W    (JW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job_in),
		.pop    (pop),
		.dout   (job_out),
		.status (q_status)
	);

	tts_back #(
		.CW(COORD_WIDTH),
		.JW(JW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.job        (job_out),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tan_x      (tan_x),
		.tan_y      (tan_y),
		.tan_z      (tan_z),
		.bitan_x    (bitan_x),
		.bitan_y    (bitan_y),
		.bitan_z    (bitan_z),
		.degenerate (degenerate),
		.clipped    (clipped)
	);

endmodule

`default_nettype wire

[src/tts_checker.sv]
`default_nettype none

module tts_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic signed [tts_pkg::OUT_W-1:0]  tan_x,
	input wire logic signed [tts_pkg::OUT_W-1:0]  tan_y,
	input wire logic signed [tts_pkg::OUT_W-1:0]  tan_z,
	input wire logic signed [tts_pkg::OUT_W-1:0]  bitan_x,
	input wire logic signed [tts_pkg::OUT_W-1:0]  bitan_y,
	input wire logic signed [tts_pkg::OUT_W-1:0]  bitan_z,
	input wire logic                              degenerate,
	input wire logic                              clipped
);
	import tts_pkg::*;

	localparam logic [OUT_W-1:0] SAT_HI = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic [OUT_W-1:0] SAT_LO = {1'b1, {(OUT_W - 1){1'b0}}};

	// Stalled transaction stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(tan_x) && $stable(bitan_z) && $stable(clipped))
		else $error("result changed while stalled");

	// Degenerate result carries zero vectors and no clip
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> tan_x == '0 && tan_y == '0 && tan_z == '0 &&
			bitan_x == '0 && bitan_y == '0 && bitan_z == '0 && !clipped)
		else $error("degenerate result not zero");

	// Clip flag implies a saturated component
	a_clip_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |->
			tan_x == SAT_HI || tan_x == SAT_LO || tan_y == SAT_HI || tan_y == SAT_LO ||
			tan_z == SAT_HI || tan_z == SAT_LO || bitan_x == SAT_HI ||
			bitan_x == SAT_LO || bitan_y == SAT_HI || bitan_y == SAT_LO ||
			bitan_z == SAT_HI || bitan_z == SAT_LO)
		else $error("clip flag without saturated component");

endmodule

bind triangle_tangent_space tts_checker u_tts_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
	import tts_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int LIMIT_CYCLES = 2000000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic signed [CW-1:0]     px, py, pz;
		logic signed [UV_W-1:0]   u, v;
		logic signed [NORM_W-1:0] nx, ny, nz;
		bit                       first;
	} vertex_t;

	typedef struct {
		logic signed [OUT_W-1:0] tn [3];
		logic signed [OUT_W-1:0] bt [3];
		bit                      degen;
		bit                      clip;
	} frame_t;

	// Tangent frame predictor and store of expected frames
	class frame_board;
		longint  pos [4][3];
		longint  uv [4][2];
		longint  nrm [4][3];
		int      vidx;
		bit      enable;
		frame_t  expected_frames [$];
		int      fails;

		function new();
			vidx = 0;
			enable = 0;
			fails = 0;
		endfunction

		function automatic longint unsigned magn(longint a);
			return a < 0 ? longint'(-a) : a;
		endfunction

		// Divide on magnitudes to Q16.16, truncate, apply sign, saturate
		function automatic logic [OUT_W-1:0] qdiv(longint num, longint det, bit flip,
			inout bit clip);
			longint unsigned un, ud, q, r, m, lim;
			bit neg;
			un = magn(num);
			ud = magn(det);
			neg = ((num < 0) != (det < 0)) != flip;
			q = un / ud;
			r = un % ud;
			if (q >= 65536) m = 64'd1 << 33;
			else m = (q << 16) + ((r << 16) / ud);
			lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
			if (m > lim) begin
				m = lim;
				clip = 1;
			end
			return neg ? OUT_W'(-m) : OUT_W'(m);
		endfunction

		function automatic frame_t tangent_frame(int i0, int i1, int i2, int in0);
			frame_t f;
			longint e1 [3], e2 [3], c [3];
			longint du1, dv1, du2, dv2, det;
			logic signed [127:0] s, a, b;
			bit clip, flip, sneg, szero;
			du1 = uv[i1][0] - uv[i0][0];
			dv1 = uv[i1][1] - uv[i0][1];
			du2 = uv[i2][0] - uv[i0][0];
			dv2 = uv[i2][1] - uv[i0][1];
			det = du1 * dv2 - du2 * dv1;
			clip = 0;
			for (int i = 0; i < 3; i++) begin
				e1[i] = pos[i1][i] - pos[i0][i];
				e2[i] = pos[i2][i] - pos[i0][i];
			end
			f.degen = 0;
			f.clip = 0;
			if (det == 0) begin
				for (int i = 0; i < 3; i++) begin
					f.tn[i] = '0;
					f.bt[i] = '0;
				end
				f.degen = 1;
				return f;
			end
			c[0] = e2[1] * nrm[in0][2] - e2[2] * nrm[in0][1];
			c[1] = e2[2] * nrm[in0][0] - e2[0] * nrm[in0][2];
			c[2] = e2[0] * nrm[in0][1] - e2[1] * nrm[in0][0];
			s = '0;
			for (int i = 0; i < 3; i++) begin
				a = e1[i];
				b = c[i];
				s = s + a * b;
			end
			sneg = s < 0;
			szero = s == 0;
			flip = !szero && (sneg != (det < 0));
			for (int i = 0; i < 3; i++) begin
				f.tn[i] = qdiv(dv2 * e1[i] - dv1 * e2[i], det, flip, clip);
				f.bt[i] = qdiv(du1 * e2[i] - du2 * e1[i], det, 1'b0, clip);
			end
			f.clip = clip;
			return f;
		endfunction

		// Track the face and, while enabled, queue a frame on the third and fourth vertex
		function void note_vertex(vertex_t vx);
			int k;
			if (vx.first) vidx = 0;
			k = vidx;
			if (k > 3) return;
			pos[k][0] = vx.px; pos[k][1] = vx.py; pos[k][2] = vx.pz;
			uv[k][0] = vx.u;   uv[k][1] = vx.v;
			nrm[k][0] = vx.nx; nrm[k][1] = vx.ny; nrm[k][2] = vx.nz;
			vidx = k + 1;
			if (enable && k == 2) expected_frames = {expected_frames, tangent_frame(0, 1, 2, 0)};
			if (enable && k == 3) expected_frames = {expected_frames, tangent_frame(2, 3, 0, 2)};
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %0h want %0h", what, got, want);
			fails++;
		endtask

		task check_frame(frame_t got);
			frame_t w;
			if (expected_frames.size() == 0) begin
				report("unexpected transaction", 0, 0);
				return;
			end
			w = expected_frames.pop_front();
			for (int i = 0; i < 3; i++) begin
				if (got.tn[i] !== w.tn[i]) report($sformatf("tan[%0d]", i), got.tn[i], w.tn[i]);
				if (got.bt[i] !== w.bt[i]) report($sformatf("bitan[%0d]", i), got.bt[i], w.bt[i]);
			end
			if (got.degen !== w.degen) report("degenerate", got.degen, w.degen);
			if (got.clip !== w.clip) report("clipped", got.clip, w.clip);
		endtask
	endclass

	logic clk, arst_n;
	logic cfg_valid, cfg_ready, cfg_data;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [CW-1:0] pos_x, pos_y, pos_z;
	logic signed [UV_W-1:0] tex_u, tex_v;
	logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
	logic first_of_face;
	logic signed [OUT_W-1:0] tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z;
	logic degenerate, clipped;

	frame_board board;
	int idle_pct, stall_pct;
	int cycles;

	triangle_tangent_space uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.tex_u(tex_u), .tex_v(tex_v),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.first_of_face(first_of_face),
		.out_valid(out_valid), .out_stall(out_stall),
		.tan_x(tan_x), .tan_y(tan_y), .tan_z(tan_z),
		.bitan_x(bitan_x), .bitan_y(bitan_y), .bitan_z(bitan_z),
		.degenerate(degenerate), .clipped(clipped)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stall the result channel at random
	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	// Check each accepted result transaction
	always @(posedge clk) begin
		frame_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.tn[0] = tan_x; got.tn[1] = tan_y; got.tn[2] = tan_z;
			got.bt[0] = bitan_x; got.bt[1] = bitan_y; got.bt[2] = bitan_z;
			got.degen = degenerate;
			got.clip = clipped;
			board.check_frame(got);
		end
	end

	// Drive one vertex transaction; entered and left at a falling edge
	task send_vertex(vertex_t vx);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		pos_x = vx.px; pos_y = vx.py; pos_z = vx.pz;
		tex_u = vx.u; tex_v = vx.v;
		norm_x = vx.nx; norm_y = vx.ny; norm_z = vx.nz;
		first_of_face = vx.first;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		board.note_vertex(vx);
		@(negedge clk);
	endtask

	task write_enable(bit value);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		board.enable = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Hold until every expected frame has come, then let the back end settle
	task wait_idle();
		in_valid = 1'b0;
		while (board.expected_frames.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic vertex_t mk(longint x, longint y, longint z, longint u, longint v,
		longint nx, longint ny, longint nz, bit first);
		vertex_t vx;
		vx.px = CW'(x); vx.py = CW'(y); vx.pz = CW'(z);
		vx.u = UV_W'(u); vx.v = UV_W'(v);
		vx.nx = NORM_W'(nx); vx.ny = NORM_W'(ny); vx.nz = NORM_W'(nz);
		vx.first = first;
		return vx;
	endfunction

	// Random vertex: full range, or a small mesh-like neighborhood
	function automatic vertex_t rand_vertex(bit first, bit wide);
		vertex_t vx;
		if (wide) begin
			vx.px = CW'($urandom); vx.py = CW'($urandom); vx.pz = CW'($urandom);
			vx.u = UV_W'($urandom); vx.v = UV_W'($urandom);
		end else begin
			vx.px = CW'($signed($urandom_range(2000000)) - 1000000);
			vx.py = CW'($signed($urandom_range(2000000)) - 1000000);
			vx.pz = CW'($signed($urandom_range(2000000)) - 1000000);
			vx.u = UV_W'($urandom_range(131072));
			vx.v = UV_W'($urandom_range(131072));
		end
		vx.nx = NORM_W'($urandom); vx.ny = NORM_W'($urandom); vx.nz = NORM_W'($urandom);
		vx.first = first;
		return vx;
	endfunction

	task random_phase(int n_items);
		int sent, len;
		bit wide;
		vertex_t vx;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				// noise vertex with a random face flag
				send_vertex(rand_vertex(1'($urandom_range(1)), 1'b1));
				sent++;
			end else begin
				len = $urandom_range(3, 5);
				if ($urandom_range(9) == 0) len = $urandom_range(1, 2);
				wide = ($urandom_range(3) == 0);
				for (int i = 0; i < len; i++) begin
					vx = rand_vertex(i == 0, wide);
					// repeat a UV now and then for a zero determinant
					if (i > 0 && $urandom_range(11) == 0) begin
						vx.u = tex_u;
						vx.v = tex_v;
					end
					send_vertex(vx);
				end
				sent += len;
			end
		end
	endtask

	localparam longint PMAX = (64'sd1 << (CW - 1)) - 1;
	localparam longint PMIN = -(64'sd1 << (CW - 1));
	localparam longint UMAX = 131071;
	localparam longint UMIN = -131072;
	localparam longint NMAX = 32767;
	localparam longint NMIN = -32768;

	initial begin
		board = new();
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		pos_x = '0; pos_y = '0; pos_z = '0;
		tex_u = '0; tex_v = '0;
		norm_x = '0; norm_y = '0; norm_z = '0;
		first_of_face = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		write_enable(1'b1);

		// stream that starts with no face flag
		send_vertex(mk(0, 0, 0, 0, 0, 0, 0, 16384, 0));
		send_vertex(mk(65536, 0, 0, 65536, 0, 0, 0, 16384, 0));
		send_vertex(mk(0, 65536, 0, 0, 65536, 0, 0, 16384, 0));
		// quad at the field extremes
		send_vertex(mk(PMAX, PMAX, PMAX, UMIN, UMIN, NMAX, NMAX, NMAX, 1));
		send_vertex(mk(PMIN, PMIN, PMIN, UMAX, UMIN, NMIN, NMIN, NMIN, 0));
		send_vertex(mk(PMAX, PMIN, 0, UMIN, UMAX, NMIN, NMAX, 0, 0));
		send_vertex(mk(PMIN, PMAX, -1, UMAX, UMAX, -1, 1, NMIN, 0));
		// zero determinant: equal UVs
		send_vertex(mk(100, 200, 300, 5000, 5000, 0, 16384, 0, 1));
		send_vertex(mk(9000, -200, 30, 5000, 5000, 0, 16384, 0, 0));
		send_vertex(mk(-900, 700, 1, 5000, 5000, 0, 16384, 0, 0));
		// tiny determinant and long edges: saturation, flipped normal
		send_vertex(mk(PMIN, 0, 0, 0, 0, 0, 0, NMIN, 1));
		send_vertex(mk(PMAX, 5, 0, 1, 0, 0, 0, NMIN, 0));
		send_vertex(mk(0, PMAX, 7, 0, 1, 0, 0, NMIN, 0));
		// five-vertex face: the fifth is dropped
		send_vertex(mk(0, 0, 0, 0, 0, 0, NMAX, 0, 1));
		send_vertex(mk(65536, 0, 0, 0, 65536, 0, NMAX, 0, 0));
		send_vertex(mk(0, 0, 65536, 65536, 0, 0, NMAX, 0, 0));
		send_vertex(mk(65536, 0, 65536, 65536, 65536, 0, NMAX, 0, 0));
		send_vertex(mk(1, 2, 3, 4, 5, 6, 7, 8, 0));
		in_valid = 1'b0;

		// random phases across idling modes and both register settings
		idle_pct = 0;  stall_pct = 0;  random_phase(90);
		idle_pct = 60; stall_pct = 0;  random_phase(90);
		wait_idle();
		idle_pct = 0;  stall_pct = 60; random_phase(90);
		idle_pct = 9;  stall_pct = 9;  random_phase(90);
		wait_idle();
		write_enable(1'b0);
		random_phase(60);
		wait_idle();
		write_enable(1'b1);
		idle_pct = 60; stall_pct = 60; random_phase(60);
		idle_pct = 0;  stall_pct = 0;  random_phase(60);
		in_valid = 1'b0;

		wait_idle();
		if (board.fails == 0 && board.expected_frames.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

`default_nettype wire
